// ===== rtl/itp_pkg.sv =====
`default_nettype none
package itp_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // error codes
  localparam logic [1:0] ERR_CLOSE    = 2'd0;
  localparam logic [1:0] ERR_OPEN     = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // characters with a meaning of their own
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // one result item
  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] kind;
    logic [1:0] code;
  } res_t;

  // sequencer to result buffer
  typedef struct packed {
    logic produce;
    logic run_end;
    res_t res;
  } emit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
  endfunction

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_CARET:           p = 2'd3;
      CH_STAR, CH_SLASH:  p = 2'd2;
      CH_PLUS, CH_MINUS:  p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
`default_nettype none
// Infix to postfix converter: takes one infix character per transfer and
// returns postfix symbols, error items and an end item, with out_last_of_run
// on the final result of each input item. Each item is captured and then
// evaluated; each symbol popped off the stack in the main loop, and the
// open paren dropped by a close paren, is followed by a registered read of
// the stack RAM that brings up the new top. A function name popped after
// its close paren is also followed by that read. A finish that meets an
// open paren emits the end item from a state of its own. The block waits
// while a result is ready but cannot be stored. A result is held until
// the next result of its item or the end of the item is known and then
// moves to the output register; one finished result may wait there while
// the next item is taken, and the block holds when a further result is
// ready before the waiting one has been taken. The stack needs no
// clearing after reset.
module infix_to_postfix_converter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_command,
  input  wire logic [7:0] in_token_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_symbol,
  output logic      [1:0] out_kind,
  output logic      [1:0] out_error_code,
  output logic            out_last_of_run
);

  logic                      ram_we;
  logic [itp_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [itp_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                ram_rd_data;
  itp_pkg::emit_t            emit;
  logic                      can_produce;
  itp_pkg::res_t             out_res;

  // symbol stack storage
  itp_stack_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rd_data (ram_rd_data)
  );

  // shunting-yard sequencer
  itp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_token_char (in_token_char),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rd_data   (ram_rd_data),
    .emit          (emit),
    .can_produce   (can_produce)
  );

  // result hold and output register
  itp_result_buf u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .emit        (emit),
    .can_produce (can_produce),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .out_last    (out_last_of_run)
  );

  assign out_symbol     = out_res.symbol;
  assign out_kind       = out_res.kind;
  assign out_error_code = out_res.code;

endmodule
`default_nettype wire

// ===== rtl/itp_stack_ram.sv =====
`default_nettype none
module itp_stack_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [itp_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic                      re,
  input  wire logic [itp_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                rd_data
);

  logic [7:0] mem [itp_pkg::STACK_DEPTH];
  logic [7:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/itp_result_buf.sv =====
`default_nettype none
module itp_result_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire itp_pkg::emit_t emit,
  output logic               can_produce,
  input  wire logic          out_stall,
  output logic               out_valid,
  output itp_pkg::res_t      out_res,
  output logic               out_last
);

  logic          hold_v_r, hold_v_nxt;
  logic          hold_last_r, hold_last_nxt;
  itp_pkg::res_t hold_res_r;
  logic          out_valid_r, out_valid_nxt;
  itp_pkg::res_t out_res_r;
  logic          out_last_r;
  logic          out_free;
  logic          move;

  // the held result leaves once its successor exists or its run has ended
  assign out_free    = !out_valid_r || !out_stall;
  assign can_produce = !hold_v_r || out_free;
  assign move        = hold_v_r && out_free && (emit.produce || hold_last_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    hold_v_nxt = hold_v_r;
    if (emit.produce) begin
      hold_v_nxt = 1'b1;
    end else if (move) begin
      hold_v_nxt = 1'b0;
    end

    hold_last_nxt = hold_last_r;
    if (emit.produce) begin
      hold_last_nxt = emit.run_end;
    end else if (emit.run_end) begin
      hold_last_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      hold_last_r <= hold_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit.produce) begin
      hold_res_r <= emit.res;
    end
    if (move) begin
      out_res_r  <= hold_res_r;
      out_last_r <= hold_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  // an end item always closes its run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == itp_pkg::KIND_END |-> out_last_r)
    else $error("end item without last flag");

  // a new result never overwrites a held one that could not leave
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.produce && hold_v_r |-> out_free)
    else $error("held result overwritten");

  // a presented result that is not taken is still there next cycle
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

// ===== rtl/itp_ctrl.sv =====
`default_nettype none
module itp_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_command,
  input  wire logic [7:0]                 in_token_char,
  output logic                            ram_we,
  output logic      [itp_pkg::ADDR_W-1:0] ram_waddr,
  output logic      [7:0]                 ram_wdata,
  output logic                            ram_re,
  output logic      [itp_pkg::ADDR_W-1:0] ram_raddr,
  input  wire logic [7:0]                 ram_rd_data,
  output itp_pkg::emit_t                  emit,
  input  wire logic                       can_produce
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_EVAL       = 3'd1;
  localparam logic [2:0] S_FETCH_MAIN = 3'd2;
  localparam logic [2:0] S_FUNC       = 3'd3;
  localparam logic [2:0] S_FETCH_FUNC = 3'd4;
  localparam logic [2:0] S_FETCH_DONE = 3'd5;
  localparam logic [2:0] S_FINEND     = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [itp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      err_r, err_nxt;
  logic [7:0]                top_r, top_nxt;
  logic                      cmd_r;
  logic [7:0]                ch_r;
  logic [itp_pkg::CNT_W-1:0] cnt_m1;
  logic [itp_pkg::CNT_W-1:0] cnt_m2;
  logic                      nonempty;
  logic                      full;
  logic                      op_pops;
  logic                      push_req;

  assign cnt_m1   = count_r - itp_pkg::CNT_W'(1);
  assign cnt_m2   = count_r - itp_pkg::CNT_W'(2);
  assign nonempty = (count_r != '0);
  assign full     = (count_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign in_stall = (state_r != S_IDLE);

  // stacked operator leaves before the incoming one
  assign op_pops = nonempty && itp_pkg::is_operator(top_r) &&
                   ((itp_pkg::prec(top_r) > itp_pkg::prec(ch_r)) ||
                    ((itp_pkg::prec(top_r) == itp_pkg::prec(ch_r)) &&
                     (ch_r != itp_pkg::CH_CARET)));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[itp_pkg::ADDR_W-1:0];
    ram_wdata = ch_r;
    ram_re    = 1'b0;
    ram_raddr = cnt_m2[itp_pkg::ADDR_W-1:0];
    emit      = '0;
    push_req  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (cmd_r) begin
          // finish: flush down to an open paren, then the end item
          if (err_r || !nonempty) begin
            if (can_produce) begin
              emit.produce  = 1'b1;
              emit.run_end  = 1'b1;
              emit.res.kind = itp_pkg::KIND_END;
              count_nxt     = '0;
              err_nxt       = 1'b0;
              state_nxt     = S_IDLE;
            end
          end else if (top_r == itp_pkg::CH_LPAREN) begin
            if (can_produce) begin
              emit.produce  = 1'b1;
              emit.res.kind = itp_pkg::KIND_ERROR;
              emit.res.code = itp_pkg::ERR_OPEN;
              state_nxt     = S_FINEND;
            end
          end else if (can_produce) begin
            emit.produce    = 1'b1;
            emit.res.symbol = top_r;
            count_nxt       = cnt_m1;
            ram_re          = (count_r > itp_pkg::CNT_W'(1));
            state_nxt       = S_FETCH_MAIN;
          end
        end else if (err_r) begin
          emit.run_end = 1'b1;
          state_nxt    = S_IDLE;
        end else if (itp_pkg::is_digit(ch_r) || ch_r == itp_pkg::CH_DOT) begin
          // operand characters pass straight out
          if (can_produce) begin
            emit.produce    = 1'b1;
            emit.run_end    = 1'b1;
            emit.res.symbol = ch_r;
            state_nxt       = S_IDLE;
          end
        end else if (itp_pkg::is_letter(ch_r) || ch_r == itp_pkg::CH_LPAREN) begin
          push_req = 1'b1;
        end else if (itp_pkg::is_operator(ch_r)) begin
          if (op_pops) begin
            if (can_produce) begin
              emit.produce    = 1'b1;
              emit.res.symbol = top_r;
              count_nxt       = cnt_m1;
              ram_re          = (count_r > itp_pkg::CNT_W'(1));
              state_nxt       = S_FETCH_MAIN;
            end
          end else begin
            push_req = 1'b1;
          end
        end else if (ch_r == itp_pkg::CH_RPAREN) begin
          // close paren: unwind to the matching open paren
          if (!nonempty) begin
            if (can_produce) begin
              emit.produce  = 1'b1;
              emit.run_end  = 1'b1;
              emit.res.kind = itp_pkg::KIND_ERROR;
              emit.res.code = itp_pkg::ERR_CLOSE;
              err_nxt       = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else if (top_r == itp_pkg::CH_LPAREN) begin
            count_nxt = cnt_m1;
            ram_re    = (count_r > itp_pkg::CNT_W'(1));
            state_nxt = S_FETCH_FUNC;
          end else if (can_produce) begin
            emit.produce    = 1'b1;
            emit.res.symbol = top_r;
            count_nxt       = cnt_m1;
            ram_re          = (count_r > itp_pkg::CNT_W'(1));
            state_nxt       = S_FETCH_MAIN;
          end
        end else begin
          emit.run_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_FETCH_MAIN: begin
        top_nxt   = ram_rd_data;
        state_nxt = S_EVAL;
      end

      S_FETCH_FUNC: begin
        top_nxt   = ram_rd_data;
        state_nxt = S_FUNC;
      end

      S_FETCH_DONE: begin
        top_nxt   = ram_rd_data;
        state_nxt = S_IDLE;
      end

      S_FUNC: begin
        // function name right below the matched open paren
        if (nonempty && itp_pkg::is_letter(top_r)) begin
          if (can_produce) begin
            emit.produce    = 1'b1;
            emit.run_end    = 1'b1;
            emit.res.symbol = top_r;
            count_nxt       = cnt_m1;
            ram_re          = (count_r > itp_pkg::CNT_W'(1));
            state_nxt       = S_FETCH_DONE;
          end
        end else begin
          emit.run_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_FINEND: begin
        if (can_produce) begin
          emit.produce  = 1'b1;
          emit.run_end  = 1'b1;
          emit.res.kind = itp_pkg::KIND_END;
          count_nxt     = '0;
          err_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // push with overflow check; the cached top forwards the new entry
    if (push_req) begin
      if (full) begin
        if (can_produce) begin
          emit.produce  = 1'b1;
          emit.run_end  = 1'b1;
          emit.res.kind = itp_pkg::KIND_ERROR;
          emit.res.code = itp_pkg::ERR_OVERFLOW;
          err_nxt       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end else begin
        ram_we       = 1'b1;
        top_nxt      = ch_r;
        count_nxt    = count_r + itp_pkg::CNT_W'(1);
        emit.run_end = 1'b1;
        state_nxt    = S_IDLE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  // item capture and cached top of stack
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      ch_r  <= in_token_char;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_produce_ok: assert property (@(posedge clk) disable iff (!rst_n)
    emit.produce |-> can_produce)
    else $error("result produced while buffer blocked");

  a_transfer_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_valid |=> state_r == S_EVAL)
    else $error("accepted item not evaluated");

  a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH_MAIN |-> $past(count_r) == count_r + itp_pkg::CNT_W'(1))
    else $error("fetch without pop");

endmodule
`default_nettype wire

// ===== verif/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;

  localparam logic [1:0] NO_CODE = 2'd0;

  // one expected or observed result transfer
  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] kind;
    logic [1:0] code;
    logic       last;
  } postfix_item_t;

  // shunting-yard predictor plus in-order result check
  class postfix_scoreboard;
    logic [7:0]    stack_mem [itp_pkg::STACK_DEPTH];
    int            depth_used;
    bit            in_error;
    postfix_item_t batch_q[$];
    postfix_item_t pending_q[$];
    int            n_fail;
    int            n_inputs;
    int            n_results;
    int            n_errors;
    int            n_ends;

    function new();
      depth_used = 0;
      in_error   = 1'b0;
      n_fail     = 0;
      n_inputs   = 0;
      n_results  = 0;
      n_errors   = 0;
      n_ends     = 0;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_arith(logic [7:0] c);
      return c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS ||
             c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH ||
             c == itp_pkg::CH_CARET;
    endfunction

    function int rank(logic [7:0] c);
      if (c == itp_pkg::CH_CARET) return 3;
      if (c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH) return 2;
      if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) return 1;
      return 0;
    endfunction

    function void add(logic [7:0] sym, logic [1:0] kind, logic [1:0] code);
      postfix_item_t it;
      it.symbol = sym;
      it.kind   = kind;
      it.code   = code;
      it.last   = 1'b0;
      batch_q.insert(batch_q.size(), it);
    endfunction

    // push onto the stack, or flag overflow when full
    function void push_or_flag(logic [7:0] c);
      if (depth_used >= itp_pkg::STACK_DEPTH) begin
        add(8'h00, itp_pkg::KIND_ERROR, itp_pkg::ERR_OVERFLOW);
        in_error = 1'b1;
      end else begin
        stack_mem[depth_used] = c;
        depth_used++;
      end
    endfunction

    // predict all results caused by one accepted input transfer
    function void note_input(logic cmd, logic [7:0] ch);
      logic [7:0]    top;
      bit            matched;
      postfix_item_t tail;
      n_inputs++;
      batch_q.delete();
      if (cmd) begin
        // finish: flush down to an open paren, then the end item
        if (!in_error) begin
          while (depth_used > 0) begin
            top = stack_mem[depth_used - 1];
            if (top == itp_pkg::CH_LPAREN) begin
              add(8'h00, itp_pkg::KIND_ERROR, itp_pkg::ERR_OPEN);
              break;
            end
            add(top, itp_pkg::KIND_SYMBOL, NO_CODE);
            depth_used--;
          end
        end
        depth_used = 0;
        in_error   = 1'b0;
        add(8'h00, itp_pkg::KIND_END, NO_CODE);
      end else if (!in_error) begin
        if ((ch >= "0" && ch <= "9") || ch == itp_pkg::CH_DOT) begin
          add(ch, itp_pkg::KIND_SYMBOL, NO_CODE);
        end else if (is_alpha(ch) || ch == itp_pkg::CH_LPAREN) begin
          push_or_flag(ch);
        end else if (is_arith(ch)) begin
          // pop operators that bind tighter; caret is right-associative
          while (depth_used > 0) begin
            top = stack_mem[depth_used - 1];
            if (!is_arith(top)) break;
            if (!(rank(top) > rank(ch) ||
                  (rank(top) == rank(ch) && ch != itp_pkg::CH_CARET)))
              break;
            add(top, itp_pkg::KIND_SYMBOL, NO_CODE);
            depth_used--;
          end
          push_or_flag(ch);
        end else if (ch == itp_pkg::CH_RPAREN) begin
          matched = 1'b0;
          while (depth_used > 0) begin
            top = stack_mem[depth_used - 1];
            if (top == itp_pkg::CH_LPAREN) begin
              matched = 1'b1;
              break;
            end
            add(top, itp_pkg::KIND_SYMBOL, NO_CODE);
            depth_used--;
          end
          if (!matched) begin
            add(8'h00, itp_pkg::KIND_ERROR, itp_pkg::ERR_CLOSE);
            in_error = 1'b1;
          end else begin
            depth_used--;
            // function letter right under the paren goes out too
            if (depth_used > 0 && is_alpha(stack_mem[depth_used - 1])) begin
              add(stack_mem[depth_used - 1], itp_pkg::KIND_SYMBOL, NO_CODE);
              depth_used--;
            end
          end
        end
      end
      if (batch_q.size() > 0) begin
        tail = batch_q[batch_q.size() - 1];
        tail.last = 1'b1;
        batch_q[batch_q.size() - 1] = tail;
      end
      foreach (batch_q[i]) pending_q.insert(pending_q.size(), batch_q[i]);
    endfunction

    function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
      n_fail++;
      if (n_fail <= 200)
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endfunction

    // compare one accepted result transfer with the oldest prediction
    function void check_result(logic [7:0] sym, logic [1:0] kind, logic [1:0] code,
                               logic last);
      postfix_item_t want;
      n_results++;
      if (kind == itp_pkg::KIND_ERROR) n_errors++;
      if (kind == itp_pkg::KIND_END) n_ends++;
      if (pending_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 200)
          $display("%0t: unexpected result symbol %0h kind %0d code %0d last %0b",
                   $time, sym, kind, code, last);
        return;
      end
      want = pending_q.pop_front();
      if (sym !== want.symbol) report("symbol", want.symbol, sym);
      if (kind !== want.kind) report("kind", {6'd0, want.kind}, {6'd0, kind});
      if (code !== want.code) report("error_code", {6'd0, want.code}, {6'd0, code});
      if (last !== want.last) report("last_of_run", {7'd0, want.last}, {7'd0, last});
    endfunction

    function void flag_leftovers();
      if (pending_q.size() != 0) begin
        n_fail++;
        $display("%0t: %0d expected results never arrived, oldest symbol %0h kind %0d",
                 $time, pending_q.size(), pending_q[0].symbol, pending_q[0].kind);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_command;
  logic [7:0] in_token_char;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_symbol;
  logic [1:0] out_kind;
  logic [1:0] out_error_code;
  logic       out_last_of_run;

  postfix_scoreboard sb;
  int                in_idle_pct;
  int                out_idle_pct;
  int                items_sent;
  bit                hold_armed;
  logic [7:0]        char_q[$];
  logic [7:0]        op_set[5];

  infix_to_postfix_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_token_char  (in_token_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last_of_run(out_last_of_run)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("infix_to_postfix_converter: mismatch");
    $finish;
  end

  // result side: random stall, plus one long hold-off when armed
  initial begin : result_stall_gen
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_symbol, out_kind, out_error_code, out_last_of_run);
  end

  // offer one input transfer; entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] ch);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_token_char <= ch;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, ch);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_queue_and_finish();
    foreach (char_q[i]) send_item(1'b0, char_q[i]);
    send_item(1'b1, 8'($urandom_range(255)));
    char_q.delete();
  endtask

  // append one character to the pending expression
  function automatic void put_char(input logic [7:0] c);
    char_q.insert(char_q.size(), c);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'("A" + $urandom_range(25));
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // operand: number, parenthesized group, function call or bare letter
  task automatic add_term(input int lvl);
    int pick;
    pick = $urandom_range(9);
    if ($urandom_range(9) == 0) put_char(8'h20);
    if (lvl >= 3 || pick < 5) begin
      repeat ($urandom_range(1, 3)) put_char(rand_digit());
      if ($urandom_range(3) == 0) begin
        put_char(itp_pkg::CH_DOT);
        put_char(rand_digit());
      end
    end else if (pick < 9) begin
      if (pick >= 7) put_char(rand_letter());
      put_char(itp_pkg::CH_LPAREN);
      add_expr(lvl + 1);
      put_char(itp_pkg::CH_RPAREN);
    end else begin
      put_char(rand_letter());
    end
  endtask

  task automatic add_expr(input int lvl);
    add_term(lvl);
    repeat ($urandom_range(0, (lvl > 1) ? 2 : 4)) begin
      put_char(op_set[$urandom_range(4)]);
      add_term(lvl);
    end
  endtask

  // random mix of sequences until the item budget is spent
  task automatic run_phase(input int budget);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        // well-formed expression, sometimes with a stray paren
        add_expr(0);
        if ($urandom_range(9) == 0)
          char_q.insert($urandom_range(char_q.size()),
                        $urandom_range(1) ? itp_pkg::CH_LPAREN : itp_pkg::CH_RPAREN);
        send_queue_and_finish();
      end else if (pick < 73) begin
        // deep nesting, may run past the stack
        repeat ($urandom_range(28, 36))
          put_char($urandom_range(2) ? itp_pkg::CH_LPAREN : rand_letter());
        put_char(rand_digit());
        repeat ($urandom_range(0, 4)) put_char(itp_pkg::CH_RPAREN);
        send_queue_and_finish();
      end else if (pick < 80) begin
        // long power chain: right-associative, piles up on the stack
        put_char(rand_digit());
        repeat ($urandom_range(26, 34)) begin
          put_char(itp_pkg::CH_CARET);
          put_char(rand_digit());
        end
        send_queue_and_finish();
      end else begin
        // raw noise over the full character range, finishes included
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(3) == 0, 8'($urandom_range(255)));
      end
    end
  endtask

  // main sequence
  initial begin : main_seq
    int waited;
    sb            = new();
    op_set        = '{itp_pkg::CH_PLUS, itp_pkg::CH_MINUS, itp_pkg::CH_STAR,
                      itp_pkg::CH_SLASH, itp_pkg::CH_CARET};
    in_idle_pct   = 0;
    out_idle_pct  = 0;
    items_sent    = 0;
    hold_armed    = 1'b0;
    in_valid      = 1'b0;
    in_command    = 1'b0;
    in_token_char = 8'h00;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: all operators, function call, dot, precedence and caret order
    send_text("f(1+.)^2^3*4/5-9");
    send_item(1'b1, 8'h00);
    // close without open, then a token that must be ignored
    send_text(")7");
    send_item(1'b1, 8'hFF);
    // open paren left at finish
    send_text("(z");
    send_item(1'b1, 8'h5A);
    // ignored characters, then finish on an empty stack
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h20);
    send_item(1'b1, 8'h00);

    in_idle_pct  = 16;
    out_idle_pct = 58;
    run_phase(100);
    in_idle_pct  = 58;
    out_idle_pct = 16;
    run_phase(100);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_armed   = 1'b1;
    run_phase(100);
    in_valid <= 1'b0;

    // drain, then a short tail for stray results
    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    sb.flag_leftovers();

    $display("covered %0d input transfers, %0d results checked", sb.n_inputs,
             sb.n_results);
    $display("including %0d error items and %0d finished expressions", sb.n_errors,
             sb.n_ends);
    if (sb.n_fail == 0) begin
      $display("infix_to_postfix_converter: match");
    end else begin
      $display("infix_to_postfix_converter: mismatch");
    end
    $finish;
  end

endmodule
